### hdl/utf8d_pkg.sv
// Shared types and constants for the UTF-8 to code point decoder.
package utf8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned RemW   = 2;

  // Code point limits.
  localparam logic [CpW-1:0] CpMax   = 21'h10FFFF;
  localparam logic [CpW-1:0] SurrLow = 21'h00D800;
  localparam logic [CpW-1:0] SurrHigh = 21'h00DFFF;

  // Lead byte thresholds.
  localparam logic [ByteW-1:0] LeadTwo   = 8'h80;
  localparam logic [ByteW-1:0] LeadThree = 8'hE0;
  localparam logic [ByteW-1:0] LeadFour  = 8'hF0;
  localparam logic [ByteW-1:0] LeadBad   = 8'hF8;

  // Payload masks for lead and continuation bytes.
  localparam logic [ByteW-1:0] MaskTwo   = 8'h1F;
  localparam logic [ByteW-1:0] MaskThree = 8'h0F;
  localparam logic [ByteW-1:0] MaskFour  = 8'h07;
  localparam logic [ByteW-1:0] MaskCont  = 8'h3F;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TRUNC   = 2'd1,
    ST_BADLEAD = 2'd2,
    ST_BADCP   = 2'd3
  } status_t;

  // One input word as held in the input register.
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             string_end;
  } utf8d_in_t;

  // One result word.
  typedef struct packed {
    logic [CpW-1:0] code_point;
    status_t        status;
    logic           result_last;
  } utf8d_res_t;

endpackage

### hdl/utf8d_in_stage.sv
// Input register stage: holds one accepted byte until the decoder takes it.
module utf8d_in_stage
  import utf8d_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  utf8d_in_t in_word,
  input  logic      take,
  output logic      hold_valid,
  output utf8d_in_t hold_word
);

  logic hold_valid_next;

  // Accept a new word whenever the register is empty or drains this cycle.
  assign in_ready = !hold_valid || take;

  always_comb begin
    hold_valid_next = hold_valid;
    if (in_valid && in_ready) begin
      hold_valid_next = 1'b1;
    end else if (take) begin
      hold_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_word <= in_word;
    end
  end

endmodule

### hdl/utf8d_step.sv
// Decode step: sequence state and the per-byte decode logic.
module utf8d_step
  import utf8d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  utf8d_in_t  word,
  output logic       emit,
  output utf8d_res_t res
);

  logic [CpW-1:0]  partial_value, partial_value_next;
  logic [RemW-1:0] bytes_remaining, bytes_remaining_next;
  logic            dropping, dropping_next;

  logic [CpW-1:0]  acc;
  logic [RemW-1:0] rem_dec;
  logic [ByteW-1:0] b;
  logic            last;
  logic            err;

  assign b    = word.data_byte;
  assign last = word.string_end;

  // Continuation byte appends six bits to the running value.
  assign acc     = {partial_value[CpW-7:0], b[5:0]};
  assign rem_dec = bytes_remaining - RemW'(1);

  // Decode one byte against the sequence state.
  always_comb begin
    partial_value_next   = partial_value;
    bytes_remaining_next = bytes_remaining;
    dropping_next        = dropping;
    emit                 = 1'b0;
    err                  = 1'b0;
    res.code_point       = '0;
    res.status           = ST_OK;
    res.result_last      = last;

    if (dropping) begin
      // Skip the rest of a failed string up to its final byte.
      if (last) begin
        dropping_next        = 1'b0;
        partial_value_next   = '0;
        bytes_remaining_next = '0;
      end
    end else if (bytes_remaining == '0) begin
      if (b < LeadTwo) begin
        emit           = 1'b1;
        res.code_point = CpW'(b);
      end else if (b < LeadBad) begin
        if (b < LeadThree) begin
          partial_value_next   = CpW'(b & MaskTwo);
          bytes_remaining_next = RemW'(1);
        end else if (b < LeadFour) begin
          partial_value_next   = CpW'(b & MaskThree);
          bytes_remaining_next = RemW'(2);
        end else begin
          partial_value_next   = CpW'(b & MaskFour);
          bytes_remaining_next = RemW'(3);
        end
        if (last) begin
          err        = 1'b1;
          res.status = ST_TRUNC;
        end
      end else begin
        err        = 1'b1;
        res.status = ST_BADLEAD;
      end
    end else if (rem_dec != '0) begin
      partial_value_next   = acc;
      bytes_remaining_next = rem_dec;
      if (last) begin
        err        = 1'b1;
        res.status = ST_TRUNC;
      end
    end else begin
      // Final byte of the sequence: range and surrogate check.
      partial_value_next   = '0;
      bytes_remaining_next = '0;
      if (acc > CpMax || (acc >= SurrLow && acc <= SurrHigh)) begin
        err        = 1'b1;
        res.status = ST_BADCP;
      end else begin
        emit           = 1'b1;
        res.code_point = acc;
      end
    end

    // Any error clears the sequence and starts dropping unless the string ends.
    if (err) begin
      emit                 = 1'b1;
      res.code_point       = '0;
      partial_value_next   = '0;
      bytes_remaining_next = '0;
      dropping_next        = !last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value   <= '0;
      bytes_remaining <= '0;
      dropping        <= 1'b0;
    end else if (fire) begin
      partial_value   <= partial_value_next;
      bytes_remaining <= bytes_remaining_next;
      dropping        <= dropping_next;
    end
  end

  // While dropping, no sequence is in progress.
  a_drop_clear: assert property (@(posedge clk) disable iff (rst)
    dropping |-> (bytes_remaining == '0 && partial_value == '0))
    else $error("sequence state left over while dropping");

  // An error on a non-final byte puts the decoder into drop mode.
  a_drop_start: assert property (@(posedge clk) disable iff (rst)
    (fire && emit && res.status != ST_OK && !last) |=> dropping)
    else $error("error did not start dropping");

  // A successful result is always a valid scalar value.
  a_ok_range: assert property (@(posedge clk) disable iff (rst)
    (emit && res.status == ST_OK) |->
      (res.code_point <= CpMax && (res.code_point < SurrLow || res.code_point > SurrHigh)))
    else $error("ok result out of range");

  // The byte that ends a string always leaves the decoder idle.
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    (fire && last) |=> (!dropping && bytes_remaining == '0))
    else $error("state not idle after string end");

endmodule

### hdl/utf8d_out_stage.sv
// Output register stage: holds one result word until it is taken.
module utf8d_out_stage
  import utf8d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  utf8d_res_t load_word,
  output logic       out_valid,
  input  logic       out_ready,
  output utf8d_res_t out_word
);

  logic out_valid_next;

  // Load only happens when the register is empty or being taken.
  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= load_word;
    end
  end

endmodule

### hdl/utf8_to_codepoint_decoder.sv
// Each byte is held in the input register, its result word in the output register.
// Throughput: one byte per cycle while words are taken; the output register and
// the input register let a new byte in while a finished word waits on out_ready.
// Only completed sequences and errors yield words; state advances per byte.
// Reset (rst, synchronous) clears both valid flags and the sequence state.
// Top level of the UTF-8 to code point decoder.
module utf8_to_codepoint_decoder
  import utf8d_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ByteW-1:0]     data_byte,
  input  logic                 string_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CpW-1:0]       code_point,
  output logic [1:0]           status,
  output logic                 result_last
);

  utf8d_in_t  in_word, hold_word;
  utf8d_res_t step_res, out_word;
  logic       hold_valid;
  logic       fire;
  logic       step_emit;

  assign in_word.data_byte  = data_byte;
  assign in_word.string_end = string_end;

  // The held byte is decoded when the output register has room for its word.
  assign fire = hold_valid && (!out_valid || out_ready);

  utf8d_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .take       (fire),
    .hold_valid (hold_valid),
    .hold_word  (hold_word)
  );

  utf8d_step u_step (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .word (hold_word),
    .emit (step_emit),
    .res  (step_res)
  );

  utf8d_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && step_emit),
    .load_word (step_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  assign code_point  = out_word.code_point;
  assign status      = out_word.status;
  assign result_last = out_word.result_last;

endmodule

### tb/tb_utf8_to_codepoint_decoder.sv
// Self-checking testbench for the UTF-8 to code point decoder, with its own decode predictor.
module tb_utf8_to_codepoint_decoder;
  import utf8d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LongHold     = 200;
  localparam int unsigned RandomBytes  = 1300;
  localparam int unsigned TotalBytes   = 1800;
  localparam int unsigned MaxReported  = 10;
  localparam int unsigned SettleCycles = 20;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [ByteW-1:0] data_byte = '0;
  logic             string_end = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [CpW-1:0]   code_point;
  logic [1:0]       status;
  logic             result_last;

  // Decoder state as the predictor sees it.
  logic [CpW-1:0]  acc_value = '0;
  logic [RemW-1:0] acc_owed = '0;
  bit              skip_to_end = 1'b0;

  // Words still owed by the block, oldest first.
  utf8d_res_t pending_points[$];

  int unsigned bytes_sent = 0;
  int unsigned error_count = 0;
  bit          idling_on = 1'b0;
  bit          long_hold_req = 1'b0;
  int unsigned stall_left = 0;

  utf8_to_codepoint_decoder uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .string_end  (string_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_point  (code_point),
    .status      (status),
    .result_last (result_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fail-safe end of the run.
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic void flag_mismatch(input string msg);
    error_count++;
    if (error_count <= MaxReported) begin
      $display("%0t mismatch: %s", $realtime, msg);
    end
  endfunction

  // Advance the decode state by one byte and report the word it yields, if any.
  function automatic void decode_byte(input logic [ByteW-1:0] b, input logic e,
                                      output bit produced, output utf8d_res_t res);
    logic [CpW-1:0]   cp;
    logic [ByteW-1:0] cont_bits;
    status_t          st;
    produced = 1'b0;
    res = '0;
    cp = '0;
    st = ST_OK;
    if (skip_to_end) begin
      if (e) begin
        skip_to_end = 1'b0;
        acc_value = '0;
        acc_owed = '0;
      end
      return;
    end
    if (acc_owed == 0) begin
      // A lead byte starts a sequence or stands alone.
      if (b < LeadTwo) begin
        produced = 1'b1;
        cp = CpW'(b);
      end else if (b >= LeadBad) begin
        produced = 1'b1;
        st = ST_BADLEAD;
      end else begin
        if (b < LeadThree) begin
          acc_value = CpW'(b & MaskTwo);
          acc_owed = RemW'(1);
        end else if (b < LeadFour) begin
          acc_value = CpW'(b & MaskThree);
          acc_owed = RemW'(2);
        end else begin
          acc_value = CpW'(b & MaskFour);
          acc_owed = RemW'(3);
        end
        if (e) begin
          produced = 1'b1;
          st = ST_TRUNC;
        end
      end
    end else begin
      // A continuation byte adds six bits, unchecked.
      cont_bits = b & MaskCont;
      acc_value = {acc_value[CpW-7:0], cont_bits[5:0]};
      acc_owed = acc_owed - RemW'(1);
      if (acc_owed != 0) begin
        if (e) begin
          produced = 1'b1;
          st = ST_TRUNC;
        end
      end else begin
        produced = 1'b1;
        cp = acc_value;
        acc_value = '0;
        if (cp > CpMax || (cp >= SurrLow && cp <= SurrHigh)) begin
          st = ST_BADCP;
        end
      end
    end
    if (produced) begin
      // Errors clear the sequence and skip the rest of an unfinished string.
      if (st != ST_OK) begin
        cp = '0;
        acc_value = '0;
        acc_owed = '0;
        if (!e) begin
          skip_to_end = 1'b1;
        end
      end
      res.code_point = cp;
      res.status = st;
      res.result_last = e;
    end
  endfunction

  // Offer one byte, wait for its handshake, and record what it should yield.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic e);
    int unsigned gap;
    bit          produced;
    utf8d_res_t  res;
    @(negedge clk);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    string_end <= e;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    decode_byte(b, e, produced, res);
    if (produced) begin
      pending_points = {pending_points, res};
    end
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_all_results();
    stop_sending();
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  // One character: a lead byte of a random class and its continuation bytes.
  task automatic send_random_char(input bit last_char);
    logic [ByteW-1:0] lead;
    logic [ByteW-1:0] cont;
    int unsigned      kind;
    int unsigned      n_cont;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      lead = 8'($urandom_range(8'h00, 8'h7F));
      n_cont = 0;
    end else if (kind < 60) begin
      lead = 8'($urandom_range(8'h80, 8'hDF));
      n_cont = 1;
    end else if (kind < 80) begin
      lead = 8'($urandom_range(8'hE0, 8'hEF));
      n_cont = 2;
    end else if (kind < 93) begin
      lead = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'hF5, 8'hF7))
                                         : 8'($urandom_range(8'hF0, 8'hF4));
      n_cont = 3;
    end else begin
      lead = 8'($urandom_range(8'hF8, 8'hFF));
      n_cont = 0;
    end
    // Now and then the string stops short inside its last sequence.
    if (last_char && n_cont > 0 && $urandom_range(0, 9) == 0) begin
      n_cont = $urandom_range(0, n_cont - 1);
    end
    send_byte(lead, last_char && n_cont == 0);
    for (int i = 0; i < n_cont; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        cont = 8'($urandom);
      end else begin
        cont = {2'b10, 6'($urandom)};
      end
      send_byte(cont, last_char && i == n_cont - 1);
    end
  endtask

  // Mostly well-formed strings; some are plain noise.
  task automatic send_random_string();
    int unsigned n_items;
    n_items = $urandom_range(1, 8);
    if ($urandom_range(0, 19) == 0) begin
      for (int i = 0; i < n_items; i++) begin
        send_byte(8'($urandom), i == n_items - 1);
      end
    end else begin
      for (int i = 0; i < n_items; i++) begin
        send_random_char(i == n_items - 1);
      end
    end
  endtask

  // Valid sequences of one, two and four bytes, with extreme values of those classes.
  task automatic test_valid_sequences();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    // A continuation byte in lead position acts as a two-byte lead.
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hDF, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
  endtask

  // Every error kind, with and without the final byte carrying it.
  task automatic test_error_sequences();
    // Surrogate on the final byte: no skipping afterwards.
    send_byte(8'hED, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b1);
    // Value above the code point range, then the rest of the string skipped.
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'h41, 1'b1);
    // Invalid lead bytes, inside a string and at its end.
    send_byte(8'hF8, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b1);
    // Lead byte that is the final byte, and a string that ends mid-sequence.
    send_byte(8'hE0, 1'b1);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h80, 1'b1);
  endtask

  task automatic test_random_strings();
    idling_on = 1'b1;
    while (bytes_sent < RandomBytes) send_random_string();
  endtask

  // The receiver stalls for a long stretch so the block fills and blocks its input.
  task automatic test_backpressure_fill();
    idling_on = 1'b0;
    send_byte(8'h30, 1'b0);
    long_hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_byte(8'($urandom_range(8'h00, 8'h7F)), i == 39);
    end
    wait_all_results();
  endtask

  task automatic test_unpaced_tail();
    idling_on = 1'b0;
    while (bytes_sent < TotalBytes) send_random_string();
  endtask

  // Receiver: random stall bursts, plus one long hold on request.
  initial begin
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LongHold - 1;
        out_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 14);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each accepted word with the oldest expected one.
  always @(posedge clk) begin
    utf8d_res_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        flag_mismatch($sformatf("unexpected word code_point=%h status=%0d last=%b",
                                code_point, status, result_last));
      end else begin
        want = pending_points.pop_front();
        if (code_point !== want.code_point) begin
          flag_mismatch($sformatf("code_point expected %h, got %h",
                                  want.code_point, code_point));
        end
        if (status !== want.status) begin
          flag_mismatch($sformatf("status expected %0d, got %0d", want.status, status));
        end
        if (result_last !== want.result_last) begin
          flag_mismatch($sformatf("result_last expected %b, got %b",
                                  want.result_last, result_last));
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_valid_sequences();
    test_error_sequences();
    test_random_strings();
    test_backpressure_fill();
    test_unpaced_tail();
    wait_all_results();
    repeat (SettleCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
hdl/utf8d_pkg.sv
hdl/utf8d_in_stage.sv
hdl/utf8d_step.sv
hdl/utf8d_out_stage.sv
hdl/utf8_to_codepoint_decoder.sv
tb/tb_utf8_to_codepoint_decoder.sv
